// ===== rtl/rpac_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the point rotation core
package rpac_pkg;

	localparam int DW     = 44;
	localparam int ZW     = 26;
	localparam int GUARD  = 8;
	localparam int ZSHIFT = 9;
	localparam int PW     = 60;

	localparam logic signed [17:0] TURN_HALF    = 18'sd23040;
	localparam logic signed [17:0] TURN_FULL    = 18'sd46080;
	localparam logic signed [15:0] TURN_QUARTER = 16'sd11520;

	localparam longint GAIN_INF_Q30 = 64'sd652032874;
	localparam logic signed [PW-1:0] GAIN_ROUND = PW'(64'sd4194304);

	localparam logic [22:0] ATAN_DEG_Q16 [32] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
		23'd234379, 23'd117304, 23'd58666, 23'd29335,
		23'd14668, 23'd7334, 23'd3667, 23'd1833,
		23'd917, 23'd458, 23'd229, 23'd115,
		23'd57, 23'd29, 23'd14, 23'd7,
		23'd4, 23'd2, 23'd1, 23'd0,
		23'd0, 23'd0, 23'd0, 23'd0,
		23'd0, 23'd0, 23'd0, 23'd0
	};

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [31:0]   cx;
		logic signed [31:0]   cy;
	} pt_t;

endpackage

// ===== rtl/rotate_point_about_center_core.sv =====
`timescale 1ns / 1ps
// top level of the point rotation core
//
// rotates a q16.16 point about a q16.16 centre by a q10.7 angle in degrees
// (anticlockwise) and returns the saturated point with an overflow flag
// input beat on s_*: one point, centre and angle; output beat on m_*: one
// rotated point. every input beat gives exactly one output beat, in order
// the pipeline holds two front-end stages, one stage per cordic
// micro-rotation (STEPS of them, ROTATION_STEPS held to 8..32), then gain
// multiply, rounding and a saturating output register. one beat per cycle
// sustained while m_tready stays high
// each stage holds its own valid bit and takes a new beat when it is empty
// or its successor moves, so bubbles close up and a stall on m_tready
// backs up stage by stage to s_tready without loss or repetition
// asynchronous reset empties every stage; m_tvalid is low until the first
// beat has passed through
module rotate_point_about_center_core #(
	parameter int ROTATION_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, center_x, center_y, turn_degrees, zero pad
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rotated_x, rotated_y, overflowed, zero pad
	output logic [71:0]  m_tdata
);

	localparam int STEPS = (ROTATION_STEPS < 8) ? 8 :
		((ROTATION_STEPS > 32) ? 32 : ROTATION_STEPS);

	rpac_pkg::pt_t      chain_data  [STEPS+1];
	logic               chain_valid [STEPS+1];
	logic               chain_ready [STEPS+1];
	logic signed [31:0] rotated_x;
	logic signed [31:0] rotated_y;
	logic               overflowed;

	rpac_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.point_x      (s_tdata[31:0]),
		.point_y      (s_tdata[63:32]),
		.center_x     (s_tdata[95:64]),
		.center_y     (s_tdata[127:96]),
		.turn_degrees (s_tdata[144:128]),
		.out_valid    (chain_valid[0]),
		.out_ready    (chain_ready[0]),
		.out_data     (chain_data[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		rpac_cordic_stage #(
			.STEP (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	rpac_gain #(
		.STEPS (STEPS)
	) u_gain (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (chain_valid[STEPS]),
		.in_ready   (chain_ready[STEPS]),
		.in_data    (chain_data[STEPS]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.rotated_x  (rotated_x),
		.rotated_y  (rotated_y),
		.overflowed (overflowed)
	);

	assign m_tdata = {7'd0, overflowed, rotated_y, rotated_x};

endmodule

// ===== rtl/rpac_prep.sv =====
`timescale 1ns / 1ps
// front end: centre offset, angle reduction and exact quarter turn
module rpac_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [16:0] turn_degrees,
	output logic               out_valid,
	input  logic               out_ready,
	output rpac_pkg::pt_t      out_data
);

	logic               valid_s1;
	logic signed [32:0] dx_s1;
	logic signed [32:0] dy_s1;
	logic signed [15:0] ang_s1;
	logic signed [31:0] cx_s1;
	logic signed [31:0] cy_s1;
	logic               valid_s2;
	rpac_pkg::pt_t      data_s2;
	logic               ready_s1;
	logic               ready_s2;

	logic signed [17:0] ang_ext;
	logic signed [17:0] ang_red;
	logic signed [32:0] dx;
	logic signed [32:0] dy;

	logic signed [rpac_pkg::DW-1:0] x_ext;
	logic signed [rpac_pkg::DW-1:0] y_ext;
	logic signed [15:0]             ang_res;
	rpac_pkg::pt_t                  nxt;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		ang_ext = {turn_degrees[16], turn_degrees};
		if (ang_ext > rpac_pkg::TURN_HALF) begin
			ang_red = ang_ext - rpac_pkg::TURN_FULL;
		end else if (ang_ext <= -rpac_pkg::TURN_HALF) begin
			ang_red = ang_ext + rpac_pkg::TURN_FULL;
		end else begin
			ang_red = ang_ext;
		end
		dx = {point_x[31], point_x} - {center_x[31], center_x};
		dy = {point_y[31], point_y} - {center_y[31], center_y};
	end

	always_comb begin
		x_ext  = {{(rpac_pkg::DW-33-rpac_pkg::GUARD){dx_s1[32]}}, dx_s1,
			{rpac_pkg::GUARD{1'b0}}};
		y_ext  = {{(rpac_pkg::DW-33-rpac_pkg::GUARD){dy_s1[32]}}, dy_s1,
			{rpac_pkg::GUARD{1'b0}}};
		nxt.cx = cx_s1;
		nxt.cy = cy_s1;
		if (ang_s1 > rpac_pkg::TURN_QUARTER) begin
			nxt.x   = -y_ext;
			nxt.y   = x_ext;
			ang_res = ang_s1 - rpac_pkg::TURN_QUARTER;
		end else if (ang_s1 < -rpac_pkg::TURN_QUARTER) begin
			nxt.x   = y_ext;
			nxt.y   = -x_ext;
			ang_res = ang_s1 + rpac_pkg::TURN_QUARTER;
		end else begin
			nxt.x   = x_ext;
			nxt.y   = y_ext;
			ang_res = ang_s1;
		end
		nxt.z = {{(rpac_pkg::ZW-16-rpac_pkg::ZSHIFT){ang_res[15]}}, ang_res,
			{rpac_pkg::ZSHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			dx_s1  <= dx;
			dy_s1  <= dy;
			ang_s1 <= ang_red[15:0];
			cx_s1  <= center_x;
			cy_s1  <= center_y;
		end
		if (ready_s2 && valid_s1) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== rtl/rpac_cordic_stage.sv =====
`timescale 1ns / 1ps
// one registered cordic micro-rotation
module rpac_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rpac_pkg::pt_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rpac_pkg::pt_t out_data
);

	logic          valid_q;
	rpac_pkg::pt_t data_q;
	rpac_pkg::pt_t nxt;
	logic          ready;

	logic signed [rpac_pkg::DW-1:0] xi;
	logic signed [rpac_pkg::DW-1:0] yi;
	logic signed [rpac_pkg::DW-1:0] xs;
	logic signed [rpac_pkg::DW-1:0] ys;
	logic signed [rpac_pkg::ZW-1:0] zi;
	logic signed [rpac_pkg::ZW-1:0] at;

	assign ready    = !valid_q || out_ready;
	assign in_ready = ready;

	always_comb begin
		xi = in_data.x;
		yi = in_data.y;
		zi = in_data.z;
		xs = xi >>> STEP;
		ys = yi >>> STEP;
		at = {{(rpac_pkg::ZW-23){1'b0}}, rpac_pkg::ATAN_DEG_Q16[STEP]};
		nxt.cx = in_data.cx;
		nxt.cy = in_data.cy;
		if (!zi[rpac_pkg::ZW-1]) begin
			nxt.x = xi - ys;
			nxt.y = yi + xs;
			nxt.z = zi - at;
		end else begin
			nxt.x = xi + ys;
			nxt.y = yi - xs;
			nxt.z = zi + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== rtl/rpac_gain.sv =====
`timescale 1ns / 1ps
// gain compensation, rounding, centre add-back and saturation
module rpac_gain #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rpac_pkg::pt_t      in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] rotated_x,
	output logic signed [31:0] rotated_y,
	output logic               overflowed
);

	localparam longint GAIN_K = rpac_pkg::GAIN_INF_Q30 +
		((rpac_pkg::GAIN_INF_Q30 * 2 / 3) >>> (2 * STEPS));
	localparam logic signed [15:0] GAIN_HI = 16'(GAIN_K >>> 15);
	localparam logic signed [15:0] GAIN_LO = 16'(GAIN_K & 64'sd32767);
	localparam int PW = rpac_pkg::PW;
	localparam int RW = PW - 23;

	logic                 valid_s1;
	logic signed [PW-1:0] hx_s1;
	logic signed [PW-1:0] lx_s1;
	logic signed [PW-1:0] hy_s1;
	logic signed [PW-1:0] ly_s1;
	logic signed [31:0]   cx_s1;
	logic signed [31:0]   cy_s1;
	logic                 valid_s2;
	logic signed [PW-1:0] px_s2;
	logic signed [PW-1:0] py_s2;
	logic signed [31:0]   cx_s2;
	logic signed [31:0]   cy_s2;
	logic                 valid_s3;
	logic signed [31:0]   rx_s3;
	logic signed [31:0]   ry_s3;
	logic                 ovf_s3;
	logic                 ready_s1;
	logic                 ready_s2;
	logic                 ready_s3;

	logic signed [rpac_pkg::DW-1:0] xi;
	logic signed [rpac_pkg::DW-1:0] yi;
	logic signed [PW-1:0]           hx;
	logic signed [PW-1:0]           lx;
	logic signed [PW-1:0]           hy;
	logic signed [PW-1:0]           ly;
	logic signed [PW-1:0]           px;
	logic signed [PW-1:0]           py;
	logic signed [RW:0]             sx;
	logic signed [RW:0]             sy;
	logic                           ox;
	logic                           oy;
	logic signed [31:0]             rx;
	logic signed [31:0]             ry;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		xi = in_data.x;
		yi = in_data.y;
		hx = xi * GAIN_HI;
		lx = xi * GAIN_LO;
		hy = yi * GAIN_HI;
		ly = yi * GAIN_LO;
	end

	always_comb begin
		px = hx_s1 + (lx_s1 >>> 15) + rpac_pkg::GAIN_ROUND;
		py = hy_s1 + (ly_s1 >>> 15) + rpac_pkg::GAIN_ROUND;
	end

	always_comb begin
		sx = {{(RW-31){cx_s2[31]}}, cx_s2} + {px_s2[PW-1], px_s2[PW-1:23]};
		sy = {{(RW-31){cy_s2[31]}}, cy_s2} + {py_s2[PW-1], py_s2[PW-1:23]};
		ox = (sx[RW:31] != {(RW-30){1'b0}}) && (sx[RW:31] != {(RW-30){1'b1}});
		oy = (sy[RW:31] != {(RW-30){1'b0}}) && (sy[RW:31] != {(RW-30){1'b1}});
		if (ox) begin
			rx = {sx[RW], {31{!sx[RW]}}};
		end else begin
			rx = sx[31:0];
		end
		if (oy) begin
			ry = {sy[RW], {31{!sy[RW]}}};
		end else begin
			ry = sy[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			hx_s1 <= hx;
			lx_s1 <= lx;
			hy_s1 <= hy;
			ly_s1 <= ly;
			cx_s1 <= in_data.cx;
			cy_s1 <= in_data.cy;
		end
		if (ready_s2 && valid_s1) begin
			px_s2 <= px;
			py_s2 <= py;
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
		end
		if (ready_s3 && valid_s2) begin
			rx_s3  <= rx;
			ry_s3  <= ry;
			ovf_s3 <= ox || oy;
		end
	end

	assign out_valid  = valid_s3;
	assign rotated_x  = rx_s3;
	assign rotated_y  = ry_s3;
	assign overflowed = ovf_s3;

endmodule
